@@ rtl/core/sto_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_pkg
// Types and constants shared by the sorted timeout queue.
// ----------------------------------------------------------------------------
package sto_pkg;

  localparam int DEFAULT_SLOTS = 16;
  localparam int SLOT_W        = 4;
  localparam int DELAY_W       = 32;
  localparam int COUNT_W       = 16;
  localparam int TIME_W        = 32;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 56;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    RES_ADDED    = 3'd0,
    RES_CANCELED = 3'd1,
    RES_NOT_PEND = 3'd2,
    RES_EXPIRED  = 3'd3,
    RES_NONE_DUE = 3'd4
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CK,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_CALC,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_HD_A,
    ST_HD_B,
    ST_HD_C,
    ST_EMIT,
    ST_TICK_CK
  } state_t;

endpackage

@@ rtl/core/sorted_timeout_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_unit
// Sorted deadline queue for timeouts, kept in two small memories and walked
// by a sequencer around one shared 32-bit compare and one 32-bit adder.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                          tuser   tlast
//  s_       in   slot, delay_ms, counter_value, pad          func    -
//  m_       out  event_slot, now_time, next_compare,         event   last
//                timer_armed, pad                            _res
//
// An add first unlinks the slot when it was pending, then writes the new
// deadline, scans the queue for its place, opens a gap from the tail and
// reloads the head; a cancel unlinks the slot and reloads the head, or goes
// straight to emit when not pending; a tick emits one result per expired
// head, or a none-due result when nothing is due. s_tready is high only in idle, and a
// stalled m_tready holds the emit state. The walk is paced by the order
// memory's single read port and its registered read data.
// Reset: synchronous; clears time, queue length and pending bits. The two
// memories need no clearing pass. Results sit in an output register, so a
// new item is taken while the last result still waits on m_tready.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_unit #(
  parameter int SLOTS = sto_pkg::DEFAULT_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  // slot[3:0], delay_ms[35:4], counter_value[51:36], zero pad[55:52]
  input  logic [sto_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[1:0]
  input  logic [1:0]                     s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // event_slot[3:0], now_time[35:4], next_compare[51:36],
  // timer_armed[52], zero pad[55:53]
  output logic [sto_pkg::OUT_DATA_W-1:0] m_tdata,
  // event_res[2:0]
  output logic [2:0]                     m_tuser,
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready
);
  import sto_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot / position index
  localparam int LW = $clog2(SLOTS + 1);                // length, 0..SLOTS

  // deadline per slot, slot per queue position
  logic [TIME_W-1:0] dl_mem  [SLOTS];
  logic [IW-1:0]     ord_mem [SLOTS];

  logic              dl_we, ord_we;
  logic [IW-1:0]     dl_waddr, dl_raddr, ord_waddr, ord_raddr;
  logic [TIME_W-1:0] dl_wdata, dl_rdata;
  logic [IW-1:0]     ord_wdata, ord_rdata;

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    dl_rdata <= dl_mem[dl_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rdata <= ord_mem[ord_raddr];
  end

  // control state
  state_t             state, state_next;
  logic [LW-1:0]      len, len_next;
  logic [SLOTS-1:0]   pending, pending_next;
  logic [COUNT_W-1:0] now_count, now_count_next, now_epoch, now_epoch_next;
  logic               emitted, emitted_next;
  logic               out_valid, out_valid_next;

  // working registers
  func_t              op, op_next;
  res_t               res, res_next;
  logic [IW-1:0]      s_reg, s_next;
  logic [IW-1:0]      head_slot, head_slot_next;
  logic [TIME_W-1:0]  head_dl, head_dl_next;
  logic [DELAY_W-1:0] delay_reg, delay_next;
  logic [TIME_W-1:0]  d_reg, d_next;
  logic [LW-1:0]      pos, pos_next, idx, idx_next;

  // output register
  res_t               o_res, o_res_next;
  logic [SLOT_W-1:0]  o_slot, o_slot_next;
  logic               o_last, o_last_next;
  logic [TIME_W-1:0]  o_time, o_time_next;
  logic [COUNT_W-1:0] o_cmp, o_cmp_next;
  logic               o_armed, o_armed_next;

  logic [TIME_W-1:0]  now_time;
  logic [TIME_W-1:0]  cmp_a, cmp_b, d_sum;
  logic               cmp_gt;
  logic [LW-1:0]      idx_m1, pos_p1;
  logic [SLOT_W-1:0]  slot_r;
  logic [IW-1:0]      slot_mod;
  logic               out_free;
  state_t             unl_ret;
  func_t              func_in;

  assign now_time = {now_epoch, now_count};

  // shared compare: insert scan against the new deadline, else head against now
  assign cmp_a  = (state == ST_SCAN_C) ? dl_rdata : head_dl;
  assign cmp_b  = (state == ST_SCAN_C) ? d_reg    : now_time;
  assign cmp_gt = cmp_a > cmp_b;

  assign d_sum    = delay_reg + now_time + TIME_W'(1);
  assign idx_m1   = idx - LW'(1);
  assign pos_p1   = pos + LW'(1);
  assign out_free = !out_valid || m_tready;
  assign unl_ret  = (op == FUNC_ADD) ? ST_CALC : ST_HD_A;
  assign func_in  = func_t'(s_tuser);

  // slot number modulo SLOTS, at most eight subtract steps on four bits
  always_comb begin
    slot_r = s_tdata[SLOT_W-1:0];
    for (int k = 0; k < 8; k++) begin
      if (int'(slot_r) >= SLOTS) begin
        slot_r = slot_r - SLOT_W'(SLOTS);
      end
    end
    slot_mod = IW'(slot_r);
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    pending_next   = pending;
    now_count_next = now_count;
    now_epoch_next = now_epoch;
    emitted_next   = emitted;
    op_next        = op;
    res_next       = res;
    s_next         = s_reg;
    head_slot_next = head_slot;
    head_dl_next   = head_dl;
    delay_next     = delay_reg;
    d_next         = d_reg;
    pos_next       = pos;
    idx_next       = idx;
    o_res_next     = o_res;
    o_slot_next    = o_slot;
    o_last_next    = o_last;
    o_time_next    = o_time;
    o_cmp_next     = o_cmp;
    o_armed_next   = o_armed;
    out_valid_next = out_valid;
    dl_we          = 1'b0;
    dl_waddr       = '0;
    dl_wdata       = '0;
    dl_raddr       = '0;
    ord_we         = 1'b0;
    ord_waddr      = '0;
    ord_wdata      = '0;
    ord_raddr      = '0;
    s_tready       = (state == ST_IDLE);

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_next    = func_in;
          s_next     = slot_mod;
          delay_next = s_tdata[SLOT_W +: DELAY_W];
          pos_next   = '0;
          if (func_in == FUNC_ADD || func_in == FUNC_TICK) begin
            if (now_count > s_tdata[SLOT_W+DELAY_W +: COUNT_W]) begin
              now_epoch_next = now_epoch + COUNT_W'(1);
            end
            now_count_next = s_tdata[SLOT_W+DELAY_W +: COUNT_W];
          end
          case (func_in)
            FUNC_ADD: begin
              res_next = RES_ADDED;
              if (pending[slot_mod]) begin
                pending_next[slot_mod] = 1'b0;
                state_next = ST_FIND_RD;
              end else begin
                state_next = ST_CALC;
              end
            end
            FUNC_CANCEL: begin
              if (pending[slot_mod]) begin
                res_next = RES_CANCELED;
                pending_next[slot_mod] = 1'b0;
                state_next = ST_FIND_RD;
              end else begin
                res_next   = RES_NOT_PEND;
                state_next = ST_EMIT;
              end
            end
            FUNC_TICK: begin
              emitted_next = 1'b0;
              state_next   = ST_TICK_CK;
            end
            default: begin
              state_next = ST_IDLE;  // unused code: no result
            end
          endcase
        end
      end

      // find the slot's queue position
      ST_FIND_RD: begin
        if (pos == len) begin
          state_next = unl_ret;
        end else begin
          ord_raddr  = pos[IW-1:0];
          state_next = ST_FIND_CK;
        end
      end
      ST_FIND_CK: begin
        if (ord_rdata == s_reg) begin
          state_next = ST_SHL_RD;
        end else begin
          pos_next   = pos_p1;
          state_next = ST_FIND_RD;
        end
      end

      // close the gap at pos
      ST_SHL_RD: begin
        if ({1'b0, pos_p1} < {1'b0, len}) begin
          ord_raddr  = pos_p1[IW-1:0];
          state_next = ST_SHL_WR;
        end else begin
          len_next   = len - LW'(1);
          state_next = unl_ret;
        end
      end
      ST_SHL_WR: begin
        ord_we     = 1'b1;
        ord_waddr  = pos[IW-1:0];
        ord_wdata  = ord_rdata;
        pos_next   = pos_p1;
        state_next = ST_SHL_RD;
      end

      ST_CALC: begin
        d_next     = d_sum;
        dl_we      = 1'b1;
        dl_waddr   = s_reg;
        dl_wdata   = d_sum;
        pos_next   = '0;
        state_next = ST_SCAN_A;
      end

      // walk past every entry whose deadline is not later
      ST_SCAN_A: begin
        if (pos == len) begin
          idx_next   = len;
          state_next = (len == LW'(SLOTS)) ? ST_HD_A : ST_INS_RD;
        end else begin
          ord_raddr  = pos[IW-1:0];
          state_next = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        dl_raddr   = ord_rdata;
        state_next = ST_SCAN_C;
      end
      ST_SCAN_C: begin
        if (cmp_gt) begin
          idx_next   = len;
          state_next = (len == LW'(SLOTS)) ? ST_HD_A : ST_INS_RD;
        end else begin
          pos_next   = pos_p1;
          state_next = ST_SCAN_A;
        end
      end

      // open a gap at pos, from the tail down
      ST_INS_RD: begin
        if (idx == pos) begin
          state_next = ST_INS_PUT;
        end else begin
          ord_raddr  = idx_m1[IW-1:0];
          state_next = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        ord_we     = 1'b1;
        ord_waddr  = idx[IW-1:0];
        ord_wdata  = ord_rdata;
        idx_next   = idx_m1;
        state_next = ST_INS_RD;
      end
      ST_INS_PUT: begin
        ord_we              = 1'b1;
        ord_waddr           = pos[IW-1:0];
        ord_wdata           = s_reg;
        len_next            = len + LW'(1);
        pending_next[s_reg] = 1'b1;
        state_next          = ST_HD_A;
      end

      // reload the head slot and its deadline
      ST_HD_A: begin
        if (len == '0) begin
          state_next = ST_EMIT;
        end else begin
          ord_raddr  = '0;
          state_next = ST_HD_B;
        end
      end
      ST_HD_B: begin
        head_slot_next = ord_rdata;
        dl_raddr       = ord_rdata;
        state_next     = ST_HD_C;
      end
      ST_HD_C: begin
        head_dl_next = dl_rdata;
        state_next   = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          o_res_next     = res;
          o_slot_next    = SLOT_W'(s_reg);
          o_last_next    = (res != RES_EXPIRED) || (len == '0) || cmp_gt;
          o_time_next    = now_time;
          o_cmp_next     = (len != '0) ? head_dl[COUNT_W-1:0] : '0;
          o_armed_next   = (len != '0);
          state_next     = (res == RES_EXPIRED) ? ST_TICK_CK : ST_IDLE;
        end
      end

      ST_TICK_CK: begin
        if (len == '0 || cmp_gt) begin
          if (!emitted) begin
            res_next   = RES_NONE_DUE;
            s_next     = '0;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          res_next                = RES_EXPIRED;
          s_next                  = head_slot;
          pending_next[head_slot] = 1'b0;
          emitted_next            = 1'b1;
          pos_next                = '0;
          state_next              = ST_SHL_RD;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      pending   <= '0;
      now_count <= '0;
      now_epoch <= '0;
      emitted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      pending   <= pending_next;
      now_count <= now_count_next;
      now_epoch <= now_epoch_next;
      emitted   <= emitted_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    res       <= res_next;
    s_reg     <= s_next;
    head_slot <= head_slot_next;
    head_dl   <= head_dl_next;
    delay_reg <= delay_next;
    d_reg     <= d_next;
    pos       <= pos_next;
    idx       <= idx_next;
    o_res     <= o_res_next;
    o_slot    <= o_slot_next;
    o_last    <= o_last_next;
    o_time    <= o_time_next;
    o_cmp     <= o_cmp_next;
    o_armed   <= o_armed_next;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = o_res;
  assign m_tlast  = o_last;
  assign m_tdata  = {3'b000, o_armed, o_cmp, o_time, o_slot};

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_timeout_queue_unit. A deadline tracker keeps
// its own copy of the time, the per-slot deadlines and the ordered queue, and
// works out every event an accepted request must produce. Each event leaving
// the block is compared field by field with the oldest one still owed. A
// short directed run covers the corner cases, then bursts of random requests
// follow while the sink stalls on a rolling pattern.
// ----------------------------------------------------------------------------
module tb;
  import sto_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;  // not decoded, must give no event
  localparam int RAND_ITEMS = 210;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    res_t        res;
    logic [3:0]  slot;
    logic        last;
    logic [31:0] now_time;
    logic [15:0] next_cmp;
    logic        armed;
  } timer_event_t;

  // Tracks deadlines and owed events.
  class deadline_tracker;
    logic [15:0]  cnt_now = '0;
    logic [15:0]  epoch_now = '0;
    logic [31:0]  due_at[16];
    logic [3:0]   order_q[$];
    logic [15:0]  queued = '0;
    timer_event_t owed_q[$];
    int errors = 0;
    int shown = 0;
    int events_seen = 0;
    int expired_seen = 0;
    int deepest = 0;
    int wraps = 0;

    function logic [31:0] cur_time();
      return {epoch_now, cnt_now};
    endfunction

    function void sample_counter(logic [15:0] cv);
      if (cnt_now > cv) begin
        epoch_now = epoch_now + 16'd1;
        wraps++;
      end
      cnt_now = cv;
    endfunction

    function void drop_slot(logic [3:0] s);
      for (int i = 0; i < order_q.size(); i++) begin
        if (order_q[i] == s) begin
          order_q.delete(i);
          break;
        end
      end
      queued[s] = 1'b0;
    endfunction

    // Snapshot of time and head after the event.
    function void owe_event(res_t r, logic [3:0] s, logic last);
      timer_event_t ev;
      ev.res      = r;
      ev.slot     = s;
      ev.last     = last;
      ev.now_time = cur_time();
      ev.next_cmp = (order_q.size() > 0) ? due_at[order_q[0]][15:0] : 16'd0;
      ev.armed    = (order_q.size() > 0);
      owed_q.push_back(ev);
    endfunction

    function void apply_request(logic [1:0] f, logic [3:0] s, logic [31:0] delay,
                                logic [15:0] cv);
      logic [31:0] d;
      int pos;
      int n;
      logic [3:0] h;
      if (f == FUNC_ADD) begin
        sample_counter(cv);
        if (queued[s]) drop_slot(s);
        d = delay + cur_time() + 32'd1;
        due_at[s] = d;
        pos = 0;
        while (pos < order_q.size() && !(due_at[order_q[pos]] > d)) pos++;
        order_q.insert(pos, s);
        queued[s] = 1'b1;
        if (order_q.size() > deepest) deepest = order_q.size();
        owe_event(RES_ADDED, s, 1'b1);
      end else if (f == FUNC_CANCEL) begin
        if (queued[s]) begin
          drop_slot(s);
          owe_event(RES_CANCELED, s, 1'b1);
        end else begin
          owe_event(RES_NOT_PEND, s, 1'b1);
        end
      end else if (f == FUNC_TICK) begin
        sample_counter(cv);
        n = 0;
        while (order_q.size() > 0 && !(due_at[order_q[0]] > cur_time())) begin
          h = order_q.pop_front();
          queued[h] = 1'b0;
          owe_event(RES_EXPIRED, h,
                    order_q.size() == 0 || due_at[order_q[0]] > cur_time());
          n++;
        end
        if (n == 0) owe_event(RES_NONE_DUE, 4'd0, 1'b1);
      end
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("  mismatch %s: expected %0h, got %0h", what, exp_v, got_v);
      end
    endfunction

    function void compare_event(logic [2:0] r, logic [3:0] s, logic last,
                                logic [31:0] nt, logic [15:0] nc, logic armed);
      timer_event_t ev;
      events_seen++;
      if (owed_q.size() == 0) begin
        flag("unexpected event (res)", 32'hx, 32'(r));
        return;
      end
      ev = owed_q.pop_front();
      if (ev.res == RES_EXPIRED) expired_seen++;
      if (r !== ev.res)     flag("event_res", 32'(ev.res), 32'(r));
      if (s !== ev.slot)    flag("event_slot", 32'(ev.slot), 32'(s));
      if (last !== ev.last) flag("last", 32'(ev.last), 32'(last));
      if (nt !== ev.now_time) flag("now_time", ev.now_time, nt);
      if (nc !== ev.next_cmp) flag("next_compare", 32'(ev.next_cmp), 32'(nc));
      if (armed !== ev.armed) flag("timer_armed", 32'(ev.armed), 32'(armed));
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready;

  deadline_tracker sb = new();
  int items_sent = 0;
  int items_ignored = 0;

  sorted_timeout_queue_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Raises valid and holds the item until the block takes it.
  task automatic send_request(input logic [1:0] f, input logic [3:0] s,
                              input logic [31:0] d, input logic [15:0] cv);
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {4'b0, cv, d, s};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (f == FUNC_UNUSED) items_ignored++;
    sb.apply_request(f, s, d, cv);
  endtask

  // Caller has already lowered valid.
  task automatic drain_all();
    do @(posedge clk); while (sb.owed() != 0);
  endtask

  // Sink: rolling ready pattern, reloaded by an age counter in one of four moods.
  initial begin
    logic [15:0] rdy_pat;
    int age;
    m_tready = 1'b0;
    rdy_pat  = 16'hffff;
    age      = 0;
    forever begin
      @(posedge clk);
      m_tready <= rdy_pat[0];
      rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      age++;
      if (age == 32) begin
        age = 0;
        case ($urandom_range(0, 3))
          0: rdy_pat = 16'hffff;
          1: rdy_pat = 16'($urandom);
          2: rdy_pat = 16'($urandom & $urandom);
          default: rdy_pat = 16'($urandom | $urandom);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.compare_event(m_tuser, m_tdata[3:0], m_tlast, m_tdata[35:4],
                       m_tdata[51:36], m_tdata[52]);
  end

  initial begin
    #15_000_000;
    $display("timeout: %0d events still owed", sb.owed());
    $display("** sorted_timeout_queue_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [15:0] cnt;
    logic [31:0] dly;
    logic [31:0] last_dly;
    logic [1:0]  f;
    logic [3:0]  s;
    int n;
    int burst;
    int gap;
    int r;
    int add_pct;
    bit mid_drained;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = FUNC_TICK;
    s_tdata  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty tick, idle cancel, ties, re-add, wrap of deadline and
    // of the counter, multi-entry expiry, unused function code.
    send_request(FUNC_TICK,   4'd0,  32'd0,          16'd0);
    send_request(FUNC_CANCEL, 4'd5,  32'd0,          16'd0);
    send_request(FUNC_ADD,    4'd0,  32'd0,          16'd10);
    send_request(FUNC_ADD,    4'd15, 32'hffff_ffff,  16'd10);  // due at once
    send_request(FUNC_ADD,    4'd3,  32'd100,        16'd12);
    send_request(FUNC_ADD,    4'd4,  32'd99,         16'd13);  // same deadline
    send_request(FUNC_ADD,    4'd7,  32'h7fff_ffff,  16'd14);
    send_request(FUNC_ADD,    4'd3,  32'd50,         16'd15);  // re-add
    send_request(FUNC_CANCEL, 4'd4,  32'd0,          16'd0);
    send_request(FUNC_CANCEL, 4'd4,  32'd0,          16'd0);
    send_request(FUNC_UNUSED, 4'd9,  32'hffff_ffff,  16'hffff);
    send_request(FUNC_TICK,   4'd0,  32'd0,          16'd70);  // three expire
    send_request(FUNC_TICK,   4'd0,  32'd0,          16'd70);
    send_request(FUNC_ADD,    4'd9,  32'h0000_ffff,  16'hffff);
    send_request(FUNC_TICK,   4'd0,  32'd0,          16'h0000);  // counter wraps
    send_request(FUNC_TICK,   4'd0,  32'd0,          16'hffff);
    send_request(FUNC_ADD,    4'd12, 32'hffff_fff0,  16'h0005);  // behind now
    send_request(FUNC_CANCEL, 4'd7,  32'd0,          16'd0);
    send_request(FUNC_TICK,   4'd0,  32'd0,          16'h0006);
    send_request(FUNC_ADD,    4'd1,  32'haaaa_5555,  16'h5555);
    send_request(FUNC_ADD,    4'd2,  32'h5555_aaaa,  16'haaaa);
    send_request(FUNC_CANCEL, 4'd1,  32'd0,          16'd0);
    s_tvalid <= 1'b0;
    drain_all();

    // Random: phases of 40 items lean toward filling, mixing or draining.
    cnt         = 16'haaaa;
    last_dly    = 32'd20;
    mid_drained = 1'b0;
    n           = 0;
    while (n < RAND_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        case ((n / 40) % 3)
          0: add_pct = 65;
          1: add_pct = 45;
          default: add_pct = 25;
        endcase
        r = $urandom_range(0, 99);
        if (r < add_pct)           f = FUNC_ADD;
        else if (r < add_pct + 15) f = FUNC_CANCEL;
        else if (r < add_pct + 19) f = FUNC_UNUSED;
        else                       f = FUNC_TICK;
        s = 4'($urandom_range(0, 15));

        case ($urandom_range(0, 9))
          0: dly = $urandom;
          1: dly = 32'hffff_ffff - $urandom_range(0, 200);
          2: dly = last_dly;
          3: dly = $urandom_range(32'h1_0000, 32'h4_0000);
          default: dly = $urandom_range(0, 300);
        endcase

        // Counter: small steps mostly, sometimes a wrap or a wild jump.
        // Reused delays keep the counter still so deadlines tie.
        if (!(f == FUNC_ADD && dly == last_dly)) begin
          case ($urandom_range(0, 9))
            0: cnt = 16'($urandom);
            1: cnt = cnt + 16'($urandom_range(16'h8000, 16'hffff));
            default: cnt = cnt + 16'($urandom_range(0, 30));
          endcase
        end
        if (f == FUNC_ADD) last_dly = dly;

        send_request(f, s, dly, (f == FUNC_CANCEL) ? 16'($urandom) : cnt);
        if (f != FUNC_UNUSED) n++;
      end
      gap = $urandom_range(0, 6);
      if (!mid_drained && n >= RAND_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        drain_all();
        mid_drained = 1'b1;
      end else if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.owed() != 0) sb.flag("events never seen", 32'(sb.owed()), 32'd0);
    $display("run: %0d requests (%0d undecoded), %0d events, %0d expiries",
             items_sent, items_ignored, sb.events_seen, sb.expired_seen);
    $display("run: deepest queue %0d entries, %0d counter wraps, %0d errors",
             sb.deepest, sb.wraps, sb.errors);
    if (sb.errors == 0) begin
      $display("** sorted_timeout_queue_unit: PASSED **");
    end else begin
      $display("** sorted_timeout_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
